// ===== rtl/core/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants of the MIDI voice allocator: event codes,
// result codes, sequencer states and the voice table entry.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int DEFAULT_VOICES = 4;
  localparam int SLOT_W         = 4;
  localparam int DUTY_W         = 10;
  localparam int ADDR_W         = 4;

  localparam logic [7:0]  CODE_NOTE_ON  = 8'h09;
  localparam logic [7:0]  CODE_NOTE_OFF = 8'h08;
  localparam logic [7:0]  CHAN_MASK     = 8'h0F;
  localparam logic [6:0]  TOP_NOTE      = 7'd127;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 10'h3FF;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_BASE_PITCH = 2'd0;
  localparam logic [1:0] REG_INC_BASE   = 2'd1;
  localparam logic [1:0] REG_INC_STEP   = 2'd2;

  typedef enum logic [1:0] {
    ACT_IGNORED  = 2'd0,
    ACT_ASSIGNED = 2'd1,
    ACT_RELEASED = 2'd2,
    ACT_NO_MATCH = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_WR,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

  typedef struct packed {
    logic [6:0]  pitch;
    logic [7:0]  age;
    logic [31:0] incr;
  } voice_entry_t;

  typedef struct packed {
    logic [6:0]  base_pitch;
    logic [31:0] inc_base;
    logic [31:0] inc_step;
  } cfg_t;

endpackage

// ===== rtl/core/mva_cfg.sv =====
// ----------------------------------------------------------------------------
// mva_cfg
// APB-style configuration registers: base pitch, base increment and
// increment per semitone.
// ----------------------------------------------------------------------------
module mva_cfg
  import mva_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_PITCH: cfg_r.base_pitch <= pwdata[6:0];
        REG_INC_BASE:   cfg_r.inc_base   <= pwdata;
        REG_INC_STEP:   cfg_r.inc_step   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_PITCH: prdata = {25'd0, cfg_r.base_pitch};
      REG_INC_BASE:   prdata = cfg_r.inc_base;
      REG_INC_STEP:   prdata = cfg_r.inc_step;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/mva_table.sv =====
// ----------------------------------------------------------------------------
// mva_table
// Voice table: one synchronous memory of entries with a registered read,
// plus a valid bit per entry so that reset frees every voice.
// ----------------------------------------------------------------------------
module mva_table
  import mva_pkg::*;
#(
  parameter int VOICES = DEFAULT_VOICES,
  parameter int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output voice_entry_t     rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  voice_entry_t     wr_data
);

  voice_entry_t      mem [VOICES];
  voice_entry_t      rd_q_r;
  logic              rd_vld_r;
  logic [VOICES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written since reset is a free voice of age zero.
  always_comb begin
    rd_data = rd_q_r;
    if (!rd_vld_r) begin
      rd_data.pitch = 7'd0;
      rd_data.age   = 8'd0;
    end
  end

endmodule

// ===== rtl/core/mva_duty.sv =====
// ----------------------------------------------------------------------------
// mva_duty
// Control-voltage duty: floor(note*4096/(127-base)) saturated to 10 bits,
// by restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mva_duty
  import mva_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [6:0]        cur_note,
  input  logic [6:0]        base_pitch,
  output logic              done,
  output logic [DUTY_W-1:0] duty
);

  localparam int CNT_W = $clog2(DUTY_W + 1);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        rem_r;
  logic [6:0]        span_r;
  logic [DUTY_W-1:0] q_r;
  logic [6:0]        span;
  logic              sat;
  logic [7:0]        shifted;
  logic              fits;

  assign span = TOP_NOTE - base_pitch;
  // The quotient exceeds 10 bits exactly when note*4 reaches the span.
  assign sat  = (base_pitch == TOP_NOTE) || ({cur_note, 2'b00} >= {2'b00, span});

  assign shifted = {rem_r[6:0], 1'b0};
  assign fits    = shifted >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (cur_note == 7'd0 || sat) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
          cnt_r <= CNT_W'(DUTY_W);
        end
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      span_r <= span;
      // Below saturation note*4 is smaller than the span, so it fits.
      rem_r  <= {cur_note[5:0], 2'b00};
      if (cur_note == 7'd0) begin
        q_r <= '0;
      end else if (sat) begin
        q_r <= DUTY_MAX;
      end else begin
        q_r <= '0;
      end
    end else if (run_r) begin
      rem_r <= fits ? (shifted - {1'b0, span_r}) : shifted;
      q_r   <= {q_r[DUTY_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign duty = q_r;

endmodule

// ===== rtl/core/midi_voice_allocator_cv.sv =====
// ----------------------------------------------------------------------------
// midi_voice_allocator_cv
// Least-recently-used voice allocator for MIDI note events, with phase
// increment and control-voltage duty results.
// ----------------------------------------------------------------------------
// Use: drive in_event_code, in_status_byte and in_note and raise start while
// busy is low; the item is taken at that edge and busy rises at once. Only
// channel 0 note-on and note-off items touch the voice table; all others are
// reported as ignored. Each item gives exactly one result, shown for one
// cycle with out_valid; the receiver cannot stall it, so it must take every
// strobe. The next item is taken once busy falls again, in the cycle of the
// strobe at the earliest.
// Sequence: a note-on or note-off walks the table one entry at a time, each
// entry a memory read, then the update and write-back; a note-on then makes
// the final write, and an ignored item skips the table. The duty step then
// skips the divider when the duty is zero or saturated; otherwise the divider
// runs, one quotient bit a cycle. Reset frees all voices through valid bits
// at once, clears the gate and the current note, and zeroes the
// configuration registers. Configuration is written through the APB port
// while busy is low; the user must keep to this, as the block does not
// enforce it.
// ----------------------------------------------------------------------------
module midi_voice_allocator_cv
  import mva_pkg::*;
#(
  parameter int VOICES = DEFAULT_VOICES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_event_code,
  input  logic [7:0]        in_status_byte,
  input  logic [6:0]        in_note,
  output logic              out_valid,
  output logic [1:0]        out_action,
  output logic [SLOT_W-1:0] out_voice_slot,
  output logic [31:0]       out_increment,
  output logic [DUTY_W-1:0] out_cv_duty,
  output logic              out_gate,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [7:0]       pick_age_r, pick_age_nxt;
  logic             hit_r, hit_nxt;
  logic             op_on_r, op_on_nxt;
  logic [6:0]       note_r, note_nxt;
  logic [31:0]      diff_r, diff_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [6:0]       cur_note_r, cur_note_nxt;
  logic             gate_r, gate_nxt;
  action_t          act_r, act_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [31:0]      inc_hold_r, inc_hold_nxt;

  logic              out_valid_r, out_valid_nxt;
  action_t           out_action_r, out_action_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [31:0]       out_inc_r, out_inc_nxt;
  logic [DUTY_W-1:0] out_duty_r, out_duty_nxt;
  logic              out_gate_r, out_gate_nxt;

  logic             accept;
  logic             chan_ok;
  logic             is_on;
  logic             is_off;
  voice_entry_t     ent;
  voice_entry_t     wr_data;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             ent_free;
  logic             ent_take;
  logic             ent_match;
  logic             last;
  logic [7:0]       age_inc;
  logic [31:0]      new_incr;
  logic             div_start;
  logic             div_done;
  logic [DUTY_W-1:0] div_duty;

  mva_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Reads and writes are serialized by the sequencer: an entry is written
  // back before the next read is issued, so no forwarding is needed.
  mva_table #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (ent),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mva_duty u_duty (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .cur_note   (cur_note_r),
    .base_pitch (cfg.base_pitch),
    .done       (div_done),
    .duty       (div_duty)
  );

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && (state_r == ST_IDLE);
  assign chan_ok = (in_status_byte & CHAN_MASK) == 8'h00;
  assign is_on   = chan_ok && (in_event_code == CODE_NOTE_ON);
  assign is_off  = chan_ok && (in_event_code == CODE_NOTE_OFF);

  assign ent_free  = (ent.pitch == 7'd0);
  // The first entry always becomes the candidate; later ones compare
  // against the candidate's age as already incremented.
  assign ent_take  = (idx_r == '0) || (ent.age >= pick_age_r);
  assign ent_match = (ent.pitch == note_r);
  assign last      = (idx_r == IDX_W'(VOICES - 1));
  assign age_inc   = ent.age + 8'd1;
  assign new_incr  = cfg.inc_base + prod_r;
  assign prod_nxt  = cfg.inc_step * diff_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (is_on || is_off) ? ST_RD : ST_DIV_GO;
        end
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_on_r) begin
          state_nxt = (ent_free || last) ? ST_WR : ST_RD;
        end else begin
          state_nxt = last ? ST_DIV_GO : ST_RD;
        end
      end
      ST_WR: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    pick_age_nxt   = pick_age_r;
    hit_nxt        = hit_r;
    op_on_nxt      = op_on_r;
    note_nxt       = note_r;
    diff_nxt       = diff_r;
    cur_note_nxt   = cur_note_r;
    gate_nxt       = gate_r;
    act_nxt        = act_r;
    slot_nxt       = slot_r;
    inc_hold_nxt   = inc_hold_r;
    out_valid_nxt  = 1'b0;
    out_action_nxt = out_action_r;
    out_slot_nxt   = out_slot_r;
    out_inc_nxt    = out_inc_r;
    out_duty_nxt   = out_duty_r;
    out_gate_nxt   = out_gate_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = ent;
    div_start      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          note_nxt     = in_note;
          op_on_nxt    = is_on;
          idx_nxt      = '0;
          pick_nxt     = '0;
          pick_age_nxt = 8'd0;
          hit_nxt      = 1'b0;
          diff_nxt     = {25'd0, in_note} - {25'd0, cfg.base_pitch};
          slot_nxt     = '0;
          inc_hold_nxt = 32'd0;
          if (is_on) begin
            act_nxt = ACT_ASSIGNED;
          end else if (is_off) begin
            act_nxt = ACT_NO_MATCH;
          end else begin
            act_nxt = ACT_IGNORED;
          end
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_EVAL: begin
        if (op_on_r) begin
          if (ent_free) begin
            pick_nxt = idx_r;
          end else begin
            wr_en       = 1'b1;
            wr_data.age = age_inc;
            if (ent_take) begin
              pick_nxt     = idx_r;
              pick_age_nxt = age_inc;
            end
            if (!last) begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end else begin
          if (ent_match) begin
            wr_en         = 1'b1;
            wr_data.pitch = 7'd0;
            hit_nxt       = 1'b1;
          end
          if (last) begin
            if (hit_r || ent_match) begin
              cur_note_nxt = 7'd0;
              gate_nxt     = 1'b0;
              act_nxt      = ACT_RELEASED;
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_WR: begin
        wr_en         = 1'b1;
        wr_addr       = pick_r;
        wr_data.pitch = note_r;
        wr_data.age   = 8'd0;
        wr_data.incr  = new_incr;
        cur_note_nxt  = note_r;
        gate_nxt      = 1'b1;
        slot_nxt      = pick_r;
        inc_hold_nxt  = new_incr;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = act_r;
          out_slot_nxt   = SLOT_W'(slot_r);
          out_inc_nxt    = inc_hold_r;
          out_duty_nxt   = div_duty;
          out_gate_nxt   = gate_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_note_r  <= 7'd0;
      gate_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_note_r  <= cur_note_nxt;
      gate_r      <= gate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    pick_age_r   <= pick_age_nxt;
    hit_r        <= hit_nxt;
    op_on_r      <= op_on_nxt;
    note_r       <= note_nxt;
    diff_r       <= diff_nxt;
    prod_r       <= prod_nxt;
    act_r        <= act_nxt;
    slot_r       <= slot_nxt;
    inc_hold_r   <= inc_hold_nxt;
    out_action_r <= out_action_nxt;
    out_slot_r   <= out_slot_nxt;
    out_inc_r    <= out_inc_nxt;
    out_duty_r   <= out_duty_nxt;
    out_gate_r   <= out_gate_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_voice_slot = out_slot_r;
  assign out_increment  = out_inc_r;
  assign out_cv_duty    = out_duty_r;
  assign out_gate       = out_gate_r;

endmodule

// ===== rtl/core/mva_checker.sv =====
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mva_checker
  import mva_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_action,
  input logic [SLOT_W-1:0] out_voice_slot,
  input logic [31:0]       out_increment,
  input logic [DUTY_W-1:0] out_cv_duty,
  input logic              out_gate
);

  // Busy rises once an item is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was taken");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != ACT_ASSIGNED) |->
      (out_voice_slot == '0 && out_increment == 32'd0))
    else $error("slot or increment nonzero without an assignment");

  a_gate_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_RELEASED) |-> (!out_gate && out_cv_duty == '0))
    else $error("release left the gate open or the duty nonzero");

endmodule

bind midi_voice_allocator_cv mva_checker u_mva_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_action     (out_action),
  .out_voice_slot (out_voice_slot),
  .out_increment  (out_increment),
  .out_cv_duty    (out_cv_duty),
  .out_gate       (out_gate)
);

// ===== bench/voice_alloc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_alloc_checker
// Watches the item and result channels and the APB port of the voice
// allocator. It keeps its own voice table and register copies, works out the
// result of every accepted item and compares each strobed result with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module voice_alloc_checker
  import mva_pkg::*;
#(
  parameter int VOICES = DEFAULT_VOICES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [7:0]        in_event_code,
  input  logic [7:0]        in_status_byte,
  input  logic [6:0]        in_note,
  input  logic              out_valid,
  input  logic [1:0]        out_action,
  input  logic [SLOT_W-1:0] out_voice_slot,
  input  logic [31:0]       out_increment,
  input  logic [DUTY_W-1:0] out_cv_duty,
  input  logic              out_gate,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       fail_count,
  output logic [15:0]       pending
);

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         incr;
    logic [DUTY_W-1:0]   duty;
    logic                gate;
  } voice_result_t;

  logic [6:0]  cfg_base;
  logic [31:0] cfg_inc_base;
  logic [31:0] cfg_inc_step;

  logic [6:0]  tbl_pitch [VOICES];
  logic [7:0]  tbl_age   [VOICES];
  logic [31:0] tbl_incr  [VOICES];
  logic [6:0]  held_note;
  logic        gate_open;

  voice_result_t predicted_results [$];
  int err_total = 0;

  assign fail_count = err_total;

  function automatic logic [DUTY_W-1:0] duty_for(input logic [6:0] pitch);
    logic [31:0] quot;
    if (pitch == 7'd0) return '0;
    // A base at the top note leaves no range; the duty pins at full scale.
    if (cfg_base >= TOP_NOTE) return DUTY_MAX;
    quot = {13'd0, pitch, 12'd0} / (32'd127 - {25'd0, cfg_base});
    return (quot > 32'd1023) ? DUTY_MAX : quot[DUTY_W-1:0];
  endfunction

  function automatic voice_result_t apply_midi_event(input logic [7:0] code,
                                                     input logic [7:0] status,
                                                     input logic [6:0] note);
    voice_result_t res;
    int            pick;
    bit            found_free;
    bit            hit;
    bit            chan_ok;
    logic [31:0]   diff;
    res = '0;
    res.action = ACT_IGNORED;
    chan_ok = (status & CHAN_MASK) == 8'h00;
    if (chan_ok && code == CODE_NOTE_ON) begin
      pick = 0;
      found_free = 1'b0;
      // Entries passed before the first free one age by one; the oldest of
      // them wins when none is free, the later entry on a tie.
      for (int i = 0; i < VOICES; i++) begin
        if (!found_free) begin
          if (tbl_pitch[i] == 7'd0) begin
            pick = i;
            found_free = 1'b1;
          end else begin
            if (tbl_age[i] >= tbl_age[pick]) pick = i;
            tbl_age[i] = tbl_age[i] + 8'd1;
          end
        end
      end
      diff = {25'd0, note} - {25'd0, cfg_base};
      res.incr = cfg_inc_base + cfg_inc_step * diff;
      tbl_pitch[pick] = note;
      tbl_incr[pick] = res.incr;
      tbl_age[pick] = 8'd0;
      held_note = note;
      gate_open = 1'b1;
      res.action = ACT_ASSIGNED;
      res.slot = SLOT_W'(pick);
    end else if (chan_ok && code == CODE_NOTE_OFF) begin
      hit = 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        if (tbl_pitch[i] == note) begin
          tbl_pitch[i] = 7'd0;
          held_note = 7'd0;
          gate_open = 1'b0;
          hit = 1'b1;
        end
      end
      res.action = hit ? ACT_RELEASED : ACT_NO_MATCH;
    end
    res.duty = duty_for(held_note);
    res.gate = gate_open;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    voice_result_t want;
    if (!rst_n) begin
      cfg_base = '0;
      cfg_inc_base = '0;
      cfg_inc_step = '0;
      for (int i = 0; i < VOICES; i++) begin
        tbl_pitch[i] = '0;
        tbl_age[i] = '0;
        tbl_incr[i] = '0;
      end
      held_note = '0;
      gate_open = 1'b0;
      predicted_results.delete();
      pending <= '0;
    end else begin
      if (out_valid) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, actual action %0h",
                   $time, out_action);
          err_total++;
        end else begin
          want = predicted_results.pop_front();
          check_field("action", 32'(want.action), 32'(out_action));
          check_field("voice_slot", 32'(want.slot), 32'(out_voice_slot));
          check_field("increment", want.incr, out_increment);
          check_field("cv_duty", 32'(want.duty), 32'(out_cv_duty));
          check_field("gate", 32'(want.gate), 32'(out_gate));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE_PITCH: cfg_base = pwdata[6:0];
          REG_INC_BASE:   cfg_inc_base = pwdata;
          REG_INC_STEP:   cfg_inc_step = pwdata;
          default: ;
        endcase
      end
      if (start && !busy)
        predicted_results.push_back(apply_midi_event(in_event_code, in_status_byte, in_note));
      pending <= 16'(predicted_results.size());
    end
  end

endmodule

// ===== bench/tb_midi_voice_allocator_cv.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_voice_allocator_cv
// Drives MIDI event items into the voice allocator: a directed run through
// the corner cases, then random phases under several register settings,
// with random gaps between items. The checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_midi_voice_allocator_cv;
  import mva_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 218;
  localparam int POOL_SIZE       = 6;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [7:0]        in_event_code;
  logic [7:0]        in_status_byte;
  logic [6:0]        in_note;
  logic              out_valid;
  logic [1:0]        out_action;
  logic [SLOT_W-1:0] out_voice_slot;
  logic [31:0]       out_increment;
  logic [DUTY_W-1:0] out_cv_duty;
  logic              out_gate;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  logic [31:0] fail_count;
  logic [15:0] pending;
  int          cycle_count = 0;
  bit          burst_mode = 1'b0;
  logic [6:0]  note_pool [POOL_SIZE];

  midi_voice_allocator_cv u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_event_code  (in_event_code),
    .in_status_byte (in_status_byte),
    .in_note        (in_note),
    .out_valid      (out_valid),
    .out_action     (out_action),
    .out_voice_slot (out_voice_slot),
    .out_increment  (out_increment),
    .out_cv_duty    (out_cv_duty),
    .out_gate       (out_gate),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  voice_alloc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_event_code  (in_event_code),
    .in_status_byte (in_status_byte),
    .in_note        (in_note),
    .out_valid      (out_valid),
    .out_action     (out_action),
    .out_voice_slot (out_voice_slot),
    .out_increment  (out_increment),
    .out_cv_duty    (out_cv_duty),
    .out_gate       (out_gate),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] base, input logic [31:0] ib,
                            input logic [31:0] is);
    // Upper bits of the pitch register write are random; only seven are kept.
    write_reg(REG_BASE_PITCH, {25'($urandom), base});
    write_reg(REG_INC_BASE, ib);
    write_reg(REG_INC_STEP, is);
  endtask

  // Returns once every predicted result has arrived and the block is idle.
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic send_event(input logic [7:0] code, input logic [7:0] status,
                            input logic [6:0] note);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      // Sometimes count the gap from the end of the previous item instead.
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_event_code <= code;
    in_status_byte <= status;
    in_note <= note;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_event();
    int         kind;
    logic [7:0] code;
    logic [7:0] status;
    logic [6:0] note;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 8) note = note_pool[$urandom_range(0, POOL_SIZE - 1)];
    else note = 7'($urandom_range(0, 127));
    status = {4'($urandom_range(0, 15)), 4'h0};
    if (kind < 45) begin
      code = CODE_NOTE_ON;
    end else if (kind < 82) begin
      code = CODE_NOTE_OFF;
    end else if (kind < 90) begin
      code = ($urandom_range(0, 1) == 1) ? CODE_NOTE_ON : CODE_NOTE_OFF;
      status[3:0] = 4'($urandom_range(1, 15));
    end else begin
      code = 8'($urandom_range(0, 255));
      status = 8'($urandom_range(0, 255));
      note = 7'($urandom_range(0, 127));
    end
    send_event(code, status, note);
  endtask

  initial begin
    logic [6:0]  ph_base;
    logic [31:0] ph_inc_base;
    logic [31:0] ph_inc_step;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_event_code <= '0;
    in_status_byte <= '0;
    in_note <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset register values.
    send_event(8'h00, 8'h00, 7'd0);
    send_event(8'hFF, 8'hFF, 7'd127);
    send_event(CODE_NOTE_ON, 8'h91, 7'd60);
    send_event(CODE_NOTE_OFF, 8'h80, 7'd64);
    send_event(CODE_NOTE_ON, 8'h90, 7'd5);
    send_event(CODE_NOTE_OFF, 8'h80, 7'd5);
    start <= 1'b0;
    wait_idle();

    set_config(7'd60, 32'h1000_0000, 32'h0123_4567);
    send_event(CODE_NOTE_ON, 8'h90, 7'd60);
    send_event(CODE_NOTE_ON, 8'h90, 7'd127);
    // Note-on with note zero leaves its entry free but opens the gate.
    send_event(CODE_NOTE_ON, 8'h90, 7'd0);
    // Note-off with note zero matches the free entries.
    send_event(CODE_NOTE_OFF, 8'h80, 7'd0);
    // Below the base pitch the increment wraps.
    send_event(CODE_NOTE_ON, 8'h90, 7'd10);
    send_event(CODE_NOTE_ON, 8'h90, 7'd127);
    // Table is full now, so the oldest voices are stolen.
    send_event(CODE_NOTE_ON, 8'h90, 7'd70);
    send_event(CODE_NOTE_ON, 8'hF0, 7'd71);
    send_event(CODE_NOTE_OFF, 8'h80, 7'd127);
    send_event(CODE_NOTE_OFF, 8'h80, 7'd127);
    send_event(CODE_NOTE_OFF, 8'h00, 7'd0);
    start <= 1'b0;
    wait_idle();

    // A base at the top note makes the duty saturate.
    set_config(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(CODE_NOTE_ON, 8'h90, 7'd1);
    send_event(CODE_NOTE_ON, 8'h90, 7'd127);
    send_event(CODE_NOTE_OFF, 8'h81, 7'd1);
    send_event(8'h19, 8'h90, 7'd1);
    start <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin ph_base = 7'd0;   ph_inc_base = '1; ph_inc_step = '1; end
        1: begin ph_base = 7'd126; ph_inc_base = '0; ph_inc_step = $urandom; end
        2: begin ph_base = 7'd127; ph_inc_base = $urandom; ph_inc_step = '0; end
        4: begin ph_base = 7'd48;  ph_inc_base = $urandom; ph_inc_step = 32'd1; end
        5: begin
          ph_base = 7'($urandom_range(0, 127));
          ph_inc_base = '1;
          ph_inc_step = '0;
        end
        default: begin
          ph_base = 7'($urandom_range(0, 127));
          ph_inc_base = $urandom;
          ph_inc_step = $urandom;
        end
      endcase
      set_config(ph_base, ph_inc_base, ph_inc_step);
      // A small pool of notes keeps the table full and note-offs matching.
      for (int i = 0; i < POOL_SIZE; i++) note_pool[i] = 7'($urandom_range(0, 127));
      if (ph % 2 == 1) note_pool[0] = 7'd0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 32 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        random_event();
      end
      start <= 1'b0;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
